// ===== sv/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants for the complex integer alu
// operation codes, data width default and the queue entry layout
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_POW_STEP,
    ST_DIV_PREP,
    ST_DIV_SIGN,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_DIV_FIX,
    ST_DONE
  } st_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_add;
    logic        is_sub;
    logic        is_mul;
    logic        is_div;
    logic        is_pow;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
    logic [31:0] power_exp;
  } item_t;

endpackage

// ===== sv/complex_integer_alu.sv =====
// ----------------------------------------------------------------------------
// complex_integer_alu: integer complex arithmetic unit
// add, subtract, multiply, divide and power on 32-bit complex operands
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_tvalid/in_tready  tdata: op, a_re, a_im, b_re, b_im; tuser: power_exp
// out      out  out_tvalid/out_tready tdata: res_re, res_im; tuser: div_by_zero
//
// multiply runs one 4-step product on the shared 32x32 multiplier
// power walks 32 exponent bits, each with two 4-step products (result by base, base squared)
// divide runs two 66-step restoring divisions, skipped on a zero divisor
// one item in the back end at a time; a two-entry queue keeps accepting meanwhile
// a result waiting on out_tready holds the back end until the output register frees
// synchronous active-low reset clears the queue, sequencer and output valid
module complex_integer_alu #(
  parameter int unsigned DATA_WIDTH = cia_pkg::DataWidthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [135:0]  in_tdata,   // req_type, a_re, a_im, b_re, b_im
  input  logic [31:0]   in_tuser,   // power_exp
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // res_re, res_im
  output logic          out_tuser   // div_by_zero
);
  import cia_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  cia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_tdata(in_tdata[130:0]), .in_tuser,
    .q_valid, .q_ready, .q_item
  );

  cia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

endmodule

// ===== sv/cia_front.sv =====
// ----------------------------------------------------------------------------
// cia_front: input stage
// accepts beats, decodes the operation and feeds a short queue
// ----------------------------------------------------------------------------
module cia_front #(
  parameter int unsigned DATA_WIDTH = cia_pkg::DataWidthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [130:0]  in_tdata,
  input  logic [31:0]   in_tuser,
  output logic          q_valid,
  input  logic          q_ready,
  output cia_pkg::item_t q_item
);
  import cia_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]   cnt_r, cnt_nxt;
  item_t           dec;
  logic [2:0]      op;
  logic            push, pop;

  // operands keep only their low DATA_WIDTH bits, sign-extended
  function automatic logic [31:0] sx(input logic [31:0] v);
    logic [31:0] m;
    m = v;
    for (int i = 0; i < 32; i++) begin
      if (i >= DATA_WIDTH) m[i] = v[DATA_WIDTH-1];
    end
    return m;
  endfunction

  always_comb begin
    op            = in_tdata[2:0];
    dec.is_add    = (op == OP_ADD);
    dec.is_sub    = (op == OP_SUB);
    dec.is_mul    = (op == OP_MUL);
    dec.is_div    = (op == OP_DIV);
    dec.is_pow    = (op == OP_POW);
    dec.a_re      = sx(in_tdata[34:3]);
    dec.a_im      = sx(in_tdata[66:35]);
    dec.b_re      = sx(in_tdata[98:67]);
    dec.b_im      = sx(in_tdata[130:99]);
    dec.power_exp = in_tuser;
  end

  assign in_tready = (cnt_r != (PtrW+1)'(QueueDepth));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= dec;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PtrW+1)'(QueueDepth)) |-> !in_tready) else $error("ready when full");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("count slip");

endmodule

// ===== sv/cia_back.sv =====
// ----------------------------------------------------------------------------
// cia_back: execution stage
// one shared 32x32 multiplier, square-and-multiply power loop and a
// restoring radix-2 divider, with an output register toward the result bus
// ----------------------------------------------------------------------------
module cia_back #(
  parameter int unsigned DATA_WIDTH = cia_pkg::DataWidthDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  cia_pkg::item_t q_item,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,
  output logic           out_tuser
);
  import cia_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  st_t st_r, st_nxt;

  logic signed [31:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic [31:0]        exp_r;
  logic [5:0]         pow_cnt_r;
  logic [1:0]         mphase_r;
  logic               pow_mode_r;
  logic signed [63:0] p0_r, p1_r;
  logic [W-1:0]       r_re_r, r_im_r, bs_re_r, bs_im_r;
  logic               dz_r;
  // divider state
  logic [65:0]        den_r;
  logic [65:0]        num_r, rem_r;
  logic [6:0]         div_cnt_r;
  logic               neg_r;
  logic [65:0]        nre_r, nim_r;
  logic               nim_neg_r;
  logic [W-1:0]       qre_r;
  logic [4:0]         sub_r;
  logic [31:0]        o_re_r, o_im_r;
  logic               o_flag_r, o_valid_r;

  logic signed [31:0] mx, my;
  logic signed [63:0] mprod;
  logic [65:0]        rem_sh, rem_try;

  function automatic logic [31:0] ext(input logic [W-1:0] v);
    logic [31:0] r;
    r = 32'(signed'(v));
    return r;
  endfunction

  // multiplier operand select by sub-step
  always_comb begin
    mx = '0;
    my = '0;
    case (sub_r)
      5'd0: begin mx = a_re_r; my = b_re_r; end
      5'd1: begin mx = a_im_r; my = b_im_r; end
      5'd2: begin mx = a_re_r; my = b_im_r; end
      5'd3: begin mx = a_im_r; my = b_re_r; end
      5'd4: begin mx = b_re_r; my = b_re_r; end
      5'd5: begin mx = b_im_r; my = b_im_r; end
      default: begin mx = '0; my = '0; end
    endcase
  end
  assign mprod = mx * my;

  assign rem_sh  = {rem_r[64:0], num_r[65]};
  assign rem_try = rem_sh - den_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        if (q_item.is_mul || q_item.is_pow)    st_nxt = ST_MUL1;
        else if (q_item.is_div)                st_nxt = ST_DIV_PREP;
        else                                   st_nxt = ST_DONE;
      end
      ST_MUL1:     if (sub_r == 5'd3) st_nxt = ST_MUL2;
      ST_MUL2:     st_nxt = pow_mode_r ? ST_POW_STEP : ST_DONE;
      ST_POW_STEP: st_nxt = (pow_cnt_r == 6'd32) ? ST_DONE : ST_MUL1;
      ST_DIV_PREP: if (sub_r == 5'd5) st_nxt = ST_DIV_SIGN;
      ST_DIV_SIGN: st_nxt = (den_r == '0) ? ST_DONE : ST_DIV_RE;
      ST_DIV_RE:   if (div_cnt_r == 7'd65) st_nxt = ST_DIV_FIX;
      ST_DIV_FIX:  st_nxt = mphase_r[0] ? ST_DONE : ST_DIV_IM;
      ST_DIV_IM:   if (div_cnt_r == 7'd65) st_nxt = ST_DIV_FIX;
      ST_DONE:     if (!o_valid_r || out_tready) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready    = (st_r == ST_IDLE);
    out_tvalid = o_valid_r;
    out_tdata  = {o_im_r, o_re_r};
    out_tuser  = o_flag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      o_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      o_valid_r <= (st_r == ST_DONE) ? 1'b1 : (o_valid_r && !out_tready);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        // power: a = base, b = running result 1+0i; first step multiplies b by a
        a_re_r     <= q_item.a_re;
        a_im_r     <= q_item.a_im;
        b_re_r     <= q_item.is_pow ? 32'd1 : q_item.b_re;
        b_im_r     <= q_item.is_pow ? 32'd0 : q_item.b_im;
        exp_r      <= q_item.power_exp;
        pow_cnt_r  <= '0;
        sub_r      <= '0;
        mphase_r   <= '0;
        pow_mode_r <= q_item.is_pow;
        dz_r       <= 1'b0;
        bs_re_r    <= W'(q_item.a_re);
        bs_im_r    <= W'(q_item.a_im);
        r_re_r     <= q_item.is_pow ? W'(1)
                    : W'(q_item.is_add ? q_item.a_re + q_item.b_re
                         : q_item.is_sub ? q_item.a_re - q_item.b_re : 32'd0);
        r_im_r     <= q_item.is_pow ? W'(0)
                    : W'(q_item.is_add ? q_item.a_im + q_item.b_im
                         : q_item.is_sub ? q_item.a_im - q_item.b_im : 32'd0);
      end
      ST_MUL1: begin
        case (sub_r)
          5'd0: p0_r <= mprod;
          5'd1: p0_r <= p0_r - mprod;
          5'd2: p1_r <= mprod;
          default: p1_r <= p1_r + mprod;
        endcase
        sub_r <= (sub_r == 5'd3) ? 5'd0 : sub_r + 1'b1;
      end
      ST_MUL2: begin
        if (!pow_mode_r) begin
          r_re_r <= W'(p0_r);
          r_im_r <= W'(p1_r);
        end else if (mphase_r == 2'd0) begin
          // multiply phase: product of result and base
          if (exp_r[0]) begin
            r_re_r <= W'(p0_r);
            r_im_r <= W'(p1_r);
          end
        end else begin
          bs_re_r <= W'(p0_r);
          bs_im_r <= W'(p1_r);
        end
      end
      ST_POW_STEP: begin
        // alternate: phase 0 computes r*base, phase 1 computes base*base
        if (mphase_r == 2'd0) begin
          mphase_r <= 2'd1;
          a_re_r   <= 32'(signed'(bs_re_r));
          a_im_r   <= 32'(signed'(bs_im_r));
          b_re_r   <= 32'(signed'(bs_re_r));
          b_im_r   <= 32'(signed'(bs_im_r));
        end else begin
          mphase_r  <= 2'd0;
          exp_r     <= exp_r >> 1;
          pow_cnt_r <= pow_cnt_r + 1'b1;
          a_re_r    <= 32'(signed'(bs_re_r));
          a_im_r    <= 32'(signed'(bs_im_r));
          b_re_r    <= 32'(signed'(r_re_r));
          b_im_r    <= 32'(signed'(r_im_r));
        end
      end
      ST_DIV_PREP: begin
        case (sub_r)
          5'd0: p0_r <= mprod;
          5'd1: begin
            nre_r     <= 66'(signed'(p0_r)) + 66'(signed'(mprod));
          end
          5'd2: p1_r <= mprod;
          5'd3: nim_r <= 66'(signed'(mprod)) - 66'(signed'(p1_r));
          5'd4: p0_r <= mprod;
          default: den_r <= 66'(p0_r) + 66'(mprod);
        endcase
        sub_r <= sub_r + 1'b1;
      end
      ST_DIV_SIGN: begin
        nim_neg_r <= nim_r[65];
        neg_r     <= nre_r[65];
        num_r     <= nre_r[65] ? 66'(0) - nre_r : nre_r;
        nim_r     <= nim_r[65] ? 66'(0) - nim_r : nim_r;
        rem_r     <= '0;
        div_cnt_r <= '0;
        mphase_r  <= '0;
        if (den_r == '0) dz_r <= 1'b1;
      end
      ST_DIV_RE, ST_DIV_IM: begin
        // one quotient bit per cycle, quotient shifts into num_r
        if (!rem_try[65]) begin
          rem_r <= rem_try;
          num_r <= {num_r[64:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[64:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      ST_DIV_FIX: begin
        if (!mphase_r[0]) begin
          qre_r     <= neg_r ? W'(0) - W'(num_r) : W'(num_r);
          neg_r     <= nim_neg_r;
          num_r     <= nim_r;
          rem_r     <= '0;
          div_cnt_r <= '0;
          mphase_r  <= 2'd1;
        end else begin
          r_re_r <= qre_r;
          r_im_r <= neg_r ? W'(0) - W'(num_r) : W'(num_r);
        end
      end
      ST_DONE: begin
        // load the output register only once the previous beat has left
        if (!o_valid_r || out_tready) begin
          o_re_r   <= ext(r_re_r);
          o_im_r   <= ext(r_im_r);
          o_flag_r <= dz_r;
        end
      end
      default: ;
    endcase
  end

  a_one_owner: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> (st_r == ST_IDLE)) else $error("pop outside idle");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_flag_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV_RE) |-> (den_r != '0)) else $error("divide by zero ran");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for complex_integer_alu
// drives operand beats through the input stream, predicts every complex
// result and checks it field by field under random idling and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import cia_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 400;
  // codes past the last operation produce a zero result
  localparam logic [2:0] OpNoneLo = 3'd5;
  localparam logic [2:0] OpNoneHi = 3'd7;
  localparam logic [31:0] MinInt = 32'h8000_0000;
  localparam logic [31:0] MaxInt = 32'h7fff_ffff;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
    logic [31:0] power_exp;
  } cplx_req_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
  } cplx_res_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [135:0]  in_tdata;   // req_type, a_re, a_im, b_re, b_im
  logic [31:0]   in_tuser;   // power_exp
  logic          out_tvalid;
  logic          out_tready;
  logic [63:0]   out_tdata;  // res_re, res_im
  logic          out_tuser;  // div_by_zero

  cplx_res_t     result_q[$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_cycles;

  complex_integer_alu u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("complex_integer_alu verification failed");
        $finish;
      end
    end
  end

  // complex product wrapped to 32 bits
  function automatic cplx_res_t cplx_mul(cplx_res_t x, cplx_res_t y);
    cplx_res_t r;
    r.re = x.re * y.re - x.im * y.im;
    r.im = x.re * y.im + x.im * y.re;
    r.dz = 1'b0;
    return r;
  endfunction

  // (p1 + p2) / den truncated toward zero, low 32 bits
  function automatic logic [31:0] trunc_quot(longint p1, longint p2, logic [63:0] den);
    logic [63:0] m1, m2, m, q;
    logic        n1, n2, neg;
    n1 = p1 < 0;
    n2 = p2 < 0;
    m1 = n1 ? -p1 : p1;
    m2 = n2 ? -p2 : p2;
    if (n1 == n2) begin
      m = m1 + m2;
      neg = n1;
    end else if (m1 >= m2) begin
      m = m1 - m2;
      neg = n1;
    end else begin
      m = m2 - m1;
      neg = n2;
    end
    q = m / den;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic cplx_res_t predict_result(cplx_req_t rq);
    cplx_res_t   r, base, a, b;
    longint      r1, i1, r2, i2;
    logic [63:0] den;
    logic [31:0] e;
    r = '{re: '0, im: '0, dz: 1'b0};
    a = '{re: rq.a_re, im: rq.a_im, dz: 1'b0};
    b = '{re: rq.b_re, im: rq.b_im, dz: 1'b0};
    case (rq.op)
      OP_ADD: begin
        r.re = a.re + b.re;
        r.im = a.im + b.im;
      end
      OP_SUB: begin
        r.re = a.re - b.re;
        r.im = a.im - b.im;
      end
      OP_MUL: r = cplx_mul(a, b);
      OP_DIV: begin
        r1 = longint'($signed(rq.a_re));
        i1 = longint'($signed(rq.a_im));
        r2 = longint'($signed(rq.b_re));
        i2 = longint'($signed(rq.b_im));
        den = 64'(r2 * r2) + 64'(i2 * i2);
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = trunc_quot(r1 * r2, i1 * i2, den);
          r.im = trunc_quot(i1 * r2, -(r1 * i2), den);
        end
      end
      OP_POW: begin
        base = a;
        r.re = 32'd1;
        e = rq.power_exp;
        while (e != 0) begin
          if (e[0]) r = cplx_mul(r, base);
          base = cplx_mul(base, base);
          e = e >> 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one operand beat; may idle first, otherwise valid stays high back to back
  task automatic send_req(cplx_req_t rq);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, rq.b_im, rq.b_re, rq.a_im, rq.a_re, rq.op};
    in_tuser  <= rq.power_exp;
    do @(posedge clk); while (!in_tready);
    result_q.push_back(predict_result(rq));
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  function automatic cplx_req_t make_req(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                                         logic [31:0] br, logic [31:0] bi, logic [31:0] e);
    cplx_req_t rq;
    rq = '{op: op, a_re: ar, a_im: ai, b_re: br, b_im: bi, power_exp: e};
    return rq;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(7))
      0: return MinInt;
      1: return MaxInt;
      2: return 32'($urandom_range(0, 20)) - 32'd10;
      3: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic cplx_req_t rand_req();
    cplx_req_t rq;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) rq.op = OP_ADD;
    else if (pick < 40) rq.op = OP_SUB;
    else if (pick < 60) rq.op = OP_MUL;
    else if (pick < 80) rq.op = OP_DIV;
    else if (pick < 95) rq.op = OP_POW;
    else rq.op = 3'($urandom_range(OpNoneLo, OpNoneHi));
    rq.a_re = rand_part();
    rq.a_im = rand_part();
    rq.b_re = rand_part();
    rq.b_im = rand_part();
    if (rq.op == OP_DIV && $urandom_range(9) == 0) begin
      rq.b_re = '0;
      rq.b_im = '0;
    end
    rq.power_exp = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 12));
    return rq;
  endfunction

  // receiver side: random stalls plus an optional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  initial begin
    cplx_res_t exp_res;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat re=%h im=%h dz=%b", $time,
                   out_tdata[31:0], out_tdata[63:32], out_tuser);
          errors++;
        end else begin
          exp_res = result_q.pop_front();
          if (out_tdata[31:0] !== exp_res.re) begin
            $display("%0t: res_re expected %h actual %h", $time, exp_res.re, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== exp_res.im) begin
            $display("%0t: res_im expected %h actual %h", $time, exp_res.im,
                     out_tdata[63:32]);
            errors++;
          end
          if (out_tuser !== exp_res.dz) begin
            $display("%0t: div_by_zero expected %b actual %b", $time, exp_res.dz, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_req(make_req(OP_ADD, MaxInt, MinInt, 32'd1, 32'hffff_ffff, '0));
    send_req(make_req(OP_ADD, MinInt, MaxInt, MinInt, MaxInt, '1));
    send_req(make_req(OP_SUB, MinInt, MaxInt, 32'd1, 32'hffff_ffff, '0));
    send_req(make_req(OP_SUB, '0, '0, MinInt, MaxInt, '0));
    send_req(make_req(OP_MUL, MinInt, MinInt, MinInt, MinInt, '0));
    send_req(make_req(OP_MUL, MaxInt, MinInt, MaxInt, MaxInt, '0));
    send_req(make_req(OP_MUL, 32'd3, 32'd4, 32'd5, 32'hffff_fffe, '0));
    send_req(make_req(OP_DIV, 32'd7, 32'd9, '0, '0, '0));
    send_req(make_req(OP_DIV, '0, '0, '0, '0, '1));
    send_req(make_req(OP_DIV, MinInt, MinInt, 32'd1, 32'd0, '0));
    send_req(make_req(OP_DIV, MaxInt, MinInt, 32'd1, 32'hffff_ffff, '0));
    send_req(make_req(OP_DIV, MinInt, MinInt, MinInt, MinInt, '0));
    send_req(make_req(OP_DIV, 32'hffff_fff9, 32'd5, 32'd2, 32'd1, '0));
    send_req(make_req(OP_DIV, 32'd1, 32'd1, MaxInt, MinInt, '0));
    send_req(make_req(OP_POW, 32'd3, 32'd2, '0, '0, '0));
    send_req(make_req(OP_POW, MinInt, MaxInt, '1, '1, 32'd1));
    send_req(make_req(OP_POW, 32'd1, 32'd1, '0, '0, '1));
    send_req(make_req(OP_POW, MaxInt, MinInt, '0, '0, 32'h8000_0000));
    send_req(make_req(OP_POW, 32'd2, 32'hffff_ffff, '0, '0, 32'd13));
    send_req(make_req(OpNoneLo, MaxInt, MaxInt, MinInt, MinInt, '1));
    send_req(make_req(3'd6, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5));
    send_req(make_req(OpNoneHi, '1, '1, '1, '1, '1));
    end_stream();
  endtask

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_req(rand_req());
    end_stream();
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 3000;
    repeat (40) send_req(rand_req());
    end_stream();
  endtask

  initial begin
    errors      = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 54, 0);
    test_random(500, 0, 54);
    test_random(500, 18, 18);
    test_backpressure();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("complex_integer_alu verification clean");
    end else begin
      $display("complex_integer_alu verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cia_pkg.sv
sv/cia_front.sv
sv/cia_back.sv
sv/complex_integer_alu.sv
tb/tb.sv
